// ----- hw/rtl/erai_pkg.sv -----
// shared types, constants and helpers for the euler rotate / accel integrate block
// no dependencies; used by every module in hw/rtl
`default_nettype none

package erai_pkg;

    typedef logic signed [31:0] t_q16;

    typedef struct packed {
        t_q16 z;
        t_q16 y;
        t_q16 x;
    } t_vec3;

    typedef struct packed {
        t_q16 cy;
        t_q16 sy;
        t_q16 cp;
        t_q16 sp;
        t_q16 cr;
        t_q16 sr;
    } t_trig;

    typedef enum logic [1:0] {
        CMD_DIR   = 2'd0,
        CMD_ACCEL = 2'd1,
        CMD_SPEED = 2'd2,
        CMD_TICK  = 2'd3
    } t_cmd;

    localparam int TwoPiQ16    = 411775;
    localparam int PiQ16       = 205887;
    localparam int HalfPiQ16   = 102944;
    localparam int CordicGain  = 652032874;
    localparam int CordicSteps = 30;
    localparam int ModSteps    = 14;
    localparam longint ModOffset = 64'd2147818400;

    function automatic logic signed [33:0] f_atan(input logic [4:0] idx);
        logic signed [33:0] v;
        case (idx)
            5'd0:  v = 34'sd843314857;
            5'd1:  v = 34'sd497837829;
            5'd2:  v = 34'sd263043837;
            5'd3:  v = 34'sd133525159;
            5'd4:  v = 34'sd67021687;
            5'd5:  v = 34'sd33543516;
            5'd6:  v = 34'sd16775851;
            5'd7:  v = 34'sd8388437;
            5'd8:  v = 34'sd4194283;
            5'd9:  v = 34'sd2097149;
            5'd10: v = 34'sd1048575;
            5'd11: v = 34'sd524287;
            5'd12: v = 34'sd262143;
            5'd13: v = 34'sd131071;
            5'd14: v = 34'sd65535;
            5'd15: v = 34'sd32767;
            5'd16: v = 34'sd16383;
            5'd17: v = 34'sd8191;
            5'd18: v = 34'sd4095;
            5'd19: v = 34'sd2047;
            5'd20: v = 34'sd1023;
            5'd21: v = 34'sd511;
            5'd22: v = 34'sd255;
            5'd23: v = 34'sd127;
            5'd24: v = 34'sd63;
            5'd25: v = 34'sd31;
            5'd26: v = 34'sd15;
            5'd27: v = 34'sd8;
            5'd28: v = 34'sd4;
            5'd29: v = 34'sd2;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

    function automatic t_q16 f_sat32(input logic signed [49:0] v);
        t_q16 r;
        if (v > 50'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -50'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/erai_cordic.sv -----
// one sine/cosine lane: angle reduction mod 2*pi, then 30 cordic rotation steps
// depends on erai_pkg
`default_nettype none

module erai_cordic (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire erai_pkg::t_q16  i_angle,
    output erai_pkg::t_q16       o_sin,
    output erai_pkg::t_q16       o_cos,
    output logic                 o_done
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOD,
        S_FOLD,
        S_ITER
    } t_state;

    localparam logic signed [20:0] LTwoPi  = 21'(erai_pkg::TwoPiQ16);
    localparam logic signed [20:0] LPi     = 21'(erai_pkg::PiQ16);
    localparam logic signed [20:0] LHalfPi = 21'(erai_pkg::HalfPiQ16);
    localparam logic [3:0] LastK = 4'(erai_pkg::ModSteps - 1);
    localparam logic [4:0] LastI = 5'(erai_pkg::CordicSteps - 1);

    t_state r_state;
    logic [33:0] r_u;
    logic [3:0] r_k;
    logic [4:0] r_i;
    logic signed [33:0] r_x, r_y, r_z;
    logic r_neg;
    erai_pkg::t_q16 r_sin, r_cos;
    logic r_done;

    logic [33:0] modc;
    logic signed [20:0] ms0, ms1;
    logic fneg;
    logic signed [33:0] dx, dy, n_x, n_y, n_z, tv;

    always_comb begin
        modc = 34'(erai_pkg::TwoPiQ16) << r_k;
        ms0 = {2'b00, r_u[18:0]};
        if (ms0 > LPi) begin
            ms0 = ms0 - LTwoPi;
        end
        ms1 = ms0;
        fneg = 1'b0;
        if (ms0 > LHalfPi) begin
            ms1 = ms0 - LPi;
            fneg = 1'b1;
        end else if (ms0 < -LHalfPi) begin
            ms1 = ms0 + LPi;
            fneg = 1'b1;
        end
        dx = r_y >>> r_i;
        dy = r_x >>> r_i;
        tv = erai_pkg::f_atan(r_i);
        if (!r_z[33]) begin
            n_x = r_x - dx;
            n_y = r_y + dy;
            n_z = r_z - tv;
        end else begin
            n_x = r_x + dx;
            n_y = r_y - dy;
            n_z = r_z + tv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_u <= {{2{i_angle[31]}}, i_angle} + 34'(erai_pkg::ModOffset);
                        r_k <= LastK;
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    if (r_u >= modc) begin
                        r_u <= r_u - modc;
                    end
                    r_k <= r_k - 4'd1;
                    if (r_k == 4'd0) begin
                        r_state <= S_FOLD;
                    end
                end
                S_FOLD: begin
                    r_z <= {ms1[19:0], 14'b0};
                    r_x <= 34'(erai_pkg::CordicGain);
                    r_y <= '0;
                    r_neg <= fneg;
                    r_i <= '0;
                    r_state <= S_ITER;
                end
                S_ITER: begin
                    r_x <= n_x;
                    r_y <= n_y;
                    r_z <= n_z;
                    r_i <= r_i + 5'd1;
                    if (r_i == LastI) begin
                        r_cos <= r_neg ? -n_x[31:0] : n_x[31:0];
                        r_sin <= r_neg ? -n_y[31:0] : n_y[31:0];
                        r_done <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_sin  = r_sin;
    assign o_cos  = r_cos;
    assign o_done = r_done;

endmodule

`default_nettype wire

// ----- hw/rtl/erai_rotate.sv -----
// merge stage: builds the zyx rotation from the three lanes, rotates the body
// accel and integrates velocity on one shared multiplier; depends on erai_pkg
`default_nettype none

module erai_rotate (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire erai_pkg::t_trig  i_trig,
    input  wire erai_pkg::t_vec3  i_accel,
    input  wire logic [31:0]      i_dt,
    input  wire erai_pkg::t_vec3  i_vel,
    output erai_pkg::t_vec3       o_vel,
    output logic                  o_done
);

    typedef enum logic [4:0] {
        OP_SR, OP_CR, OP_SP, OP_CP, OP_SY, OP_CY, OP_T0, OP_T1,
        OP_R00, OP_R01, OP_R02, OP_R10, OP_R11, OP_R12, OP_R20, OP_R21, OP_R22,
        OP_AX, OP_AY, OP_AZ, OP_W, OP_DT
    } t_opnd;

    typedef enum logic [1:0] {
        M_LOAD, M_ADD, M_SUB, M_VEL
    } t_mode;

    typedef enum logic [3:0] {
        D_NONE, D_T0, D_T1, D_R00, D_R01, D_R02, D_R10, D_R11, D_R12,
        D_R21, D_R22, D_W, D_VX, D_VY, D_VZ
    } t_dst;

    localparam logic [4:0] LastStep = 5'd25;

    logic r_busy, r_phase, r_done;
    logic [4:0] r_step;
    logic signed [67:0] r_prod;
    logic signed [49:0] r_acc;
    logic signed [33:0] r_t0, r_t1, r_r00, r_r01, r_r02, r_r10, r_r11, r_r12;
    logic signed [33:0] r_r21, r_r22, r_w;
    erai_pkg::t_vec3 r_vel;

    t_opnd sel_a, sel_b;
    t_mode mode;
    t_dst dst;
    logic signed [33:0] op_a, op_b;
    logic signed [67:0] s30, s16;
    logic signed [49:0] rnd, n_acc, vsel;
    erai_pkg::t_q16 sat;

    always_comb begin
        sel_a = OP_SR;
        sel_b = OP_SR;
        mode = M_LOAD;
        dst = D_NONE;
        case (r_step)
            5'd0:  begin sel_a = OP_CY;  sel_b = OP_SP; dst = D_T0; end
            5'd1:  begin sel_a = OP_SY;  sel_b = OP_SP; dst = D_T1; end
            5'd2:  begin sel_a = OP_CY;  sel_b = OP_CP; dst = D_R00; end
            5'd3:  begin sel_a = OP_T0;  sel_b = OP_SR; end
            5'd4:  begin sel_a = OP_SY;  sel_b = OP_CR; mode = M_SUB; dst = D_R01; end
            5'd5:  begin sel_a = OP_T0;  sel_b = OP_CR; end
            5'd6:  begin sel_a = OP_SY;  sel_b = OP_SR; mode = M_ADD; dst = D_R02; end
            5'd7:  begin sel_a = OP_SY;  sel_b = OP_CP; dst = D_R10; end
            5'd8:  begin sel_a = OP_T1;  sel_b = OP_SR; end
            5'd9:  begin sel_a = OP_CY;  sel_b = OP_CR; mode = M_ADD; dst = D_R11; end
            5'd10: begin sel_a = OP_T1;  sel_b = OP_CR; end
            5'd11: begin sel_a = OP_CY;  sel_b = OP_SR; mode = M_SUB; dst = D_R12; end
            5'd12: begin sel_a = OP_CP;  sel_b = OP_SR; dst = D_R21; end
            5'd13: begin sel_a = OP_CP;  sel_b = OP_CR; dst = D_R22; end
            5'd14: begin sel_a = OP_R00; sel_b = OP_AX; end
            5'd15: begin sel_a = OP_R01; sel_b = OP_AY; mode = M_ADD; end
            5'd16: begin sel_a = OP_R02; sel_b = OP_AZ; mode = M_ADD; dst = D_W; end
            5'd17: begin sel_a = OP_W;   sel_b = OP_DT; mode = M_VEL; dst = D_VX; end
            5'd18: begin sel_a = OP_R10; sel_b = OP_AX; end
            5'd19: begin sel_a = OP_R11; sel_b = OP_AY; mode = M_ADD; end
            5'd20: begin sel_a = OP_R12; sel_b = OP_AZ; mode = M_ADD; dst = D_W; end
            5'd21: begin sel_a = OP_W;   sel_b = OP_DT; mode = M_VEL; dst = D_VY; end
            5'd22: begin sel_a = OP_R20; sel_b = OP_AX; end
            5'd23: begin sel_a = OP_R21; sel_b = OP_AY; mode = M_ADD; end
            5'd24: begin sel_a = OP_R22; sel_b = OP_AZ; mode = M_ADD; dst = D_W; end
            5'd25: begin sel_a = OP_W;   sel_b = OP_DT; mode = M_VEL; dst = D_VZ; end
            default: begin sel_a = OP_SR; sel_b = OP_SR; end
        endcase
    end

    function automatic logic signed [33:0] f_pick(
        input t_opnd s,
        input erai_pkg::t_trig tr,
        input erai_pkg::t_vec3 ac,
        input logic [31:0] dtv,
        input logic signed [33:0] t0, t1, r00, r01, r02, r10, r11, r12, r21, r22, w
    );
        logic signed [33:0] v;
        case (s)
            OP_SR:  v = 34'(tr.sr);
            OP_CR:  v = 34'(tr.cr);
            OP_SP:  v = 34'(tr.sp);
            OP_CP:  v = 34'(tr.cp);
            OP_SY:  v = 34'(tr.sy);
            OP_CY:  v = 34'(tr.cy);
            OP_T0:  v = t0;
            OP_T1:  v = t1;
            OP_R00: v = r00;
            OP_R01: v = r01;
            OP_R02: v = r02;
            OP_R10: v = r10;
            OP_R11: v = r11;
            OP_R12: v = r12;
            OP_R20: v = -34'(tr.sp);
            OP_R21: v = r21;
            OP_R22: v = r22;
            OP_AX:  v = 34'(ac.x);
            OP_AY:  v = 34'(ac.y);
            OP_AZ:  v = 34'(ac.z);
            OP_W:   v = w;
            OP_DT:  v = {2'b00, dtv};
            default: v = '0;
        endcase
        return v;
    endfunction

    always_comb begin
        op_a = f_pick(sel_a, i_trig, i_accel, i_dt, r_t0, r_t1, r_r00, r_r01, r_r02,
                      r_r10, r_r11, r_r12, r_r21, r_r22, r_w);
        op_b = f_pick(sel_b, i_trig, i_accel, i_dt, r_t0, r_t1, r_r00, r_r01, r_r02,
                      r_r10, r_r11, r_r12, r_r21, r_r22, r_w);
        s30 = r_prod + 68'sd536870912;
        s16 = r_prod + 68'sd32768;
        if (mode == M_VEL) begin
            rnd = s16[65:16];
        end else begin
            rnd = {{12{s30[67]}}, s30[67:30]};
        end
        case (dst)
            D_VY:    vsel = 50'(r_vel.y);
            D_VZ:    vsel = 50'(r_vel.z);
            default: vsel = 50'(r_vel.x);
        endcase
        case (mode)
            M_LOAD:  n_acc = rnd;
            M_ADD:   n_acc = r_acc + rnd;
            M_SUB:   n_acc = r_acc - rnd;
            M_VEL:   n_acc = vsel + rnd;
            default: n_acc = rnd;
        endcase
        sat = erai_pkg::f_sat32(n_acc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
            r_done  <= 1'b0;
            r_step  <= '0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy) begin
                if (i_start) begin
                    r_busy  <= 1'b1;
                    r_phase <= 1'b0;
                    r_step  <= '0;
                    r_vel   <= i_vel;
                end
            end else if (!r_phase) begin
                r_prod  <= op_a * op_b;
                r_phase <= 1'b1;
            end else begin
                r_acc   <= n_acc;
                r_phase <= 1'b0;
                case (dst)
                    D_T0:  r_t0  <= n_acc[33:0];
                    D_T1:  r_t1  <= n_acc[33:0];
                    D_R00: r_r00 <= n_acc[33:0];
                    D_R01: r_r01 <= n_acc[33:0];
                    D_R02: r_r02 <= n_acc[33:0];
                    D_R10: r_r10 <= n_acc[33:0];
                    D_R11: r_r11 <= n_acc[33:0];
                    D_R12: r_r12 <= n_acc[33:0];
                    D_R21: r_r21 <= n_acc[33:0];
                    D_R22: r_r22 <= n_acc[33:0];
                    D_W:   r_w   <= 34'(sat);
                    D_VX:  r_vel.x <= sat;
                    D_VY:  r_vel.y <= sat;
                    D_VZ:  r_vel.z <= sat;
                    default: ;
                endcase
                if (r_step == LastStep) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step + 5'd1;
                end
            end
        end
    end

    assign o_vel  = r_vel;
    assign o_done = r_done;

endmodule

`default_nettype wire

// ----- hw/rtl/erai_kmh_div.sv -----
// km/h to m/s: floor((5*s + 9) / 18) by two registered reciprocal multiplications
// depends on erai_pkg
`default_nettype none

module erai_kmh_div (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire erai_pkg::t_q16  i_kmh,
    output erai_pkg::t_q16       o_vel,
    output logic                 o_done
);

    localparam logic [18:0] RecipHi = 19'd466034;
    localparam logic [20:0] RecipLo = 21'd1864136;
    localparam logic signed [35:0] Bias = 36'sd19327352832;
    localparam logic [31:0] BiasQ = 32'h40000000;

    logic r_s1, r_s2, r_done;
    logic [33:0] r_v;
    logic [17:0] r_h;
    logic [14:0] r_qh;
    logic [15:0] r_l;
    erai_pkg::t_q16 r_vel;

    logic signed [35:0] num, ofs;
    logic [36:0] prod_hi;
    logic [3:0] rh;
    logic [40:0] prod_lo;

    always_comb begin
        num = (36'(i_kmh) <<< 2) + 36'(i_kmh) + 36'sd9;
        // offset by 18 * 2^30 keeps the dividend non-negative
        ofs = num + Bias;
        // upper 18 bits divided by 9
        prod_hi = 37'(r_v[33:16]) * 37'(RecipHi);
        rh = 4'(r_h - ({r_qh, 3'b000} + 18'(r_qh)));
        // remainder joined with the lower 16 bits, divided by 9
        prod_lo = 41'({rh, r_l}) * 41'(RecipLo);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1   <= 1'b0;
            r_s2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_s1   <= i_start;
            r_s2   <= r_s1;
            r_done <= r_s2;
            if (i_start) begin
                r_v <= ofs[34:1];
            end
            if (r_s1) begin
                r_h  <= r_v[33:16];
                r_l  <= r_v[15:0];
                r_qh <= prod_hi[36:22];
            end
            if (r_s2) begin
                r_vel <= {1'b0, r_qh, prod_lo[39:24]} - BiasQ;
            end
        end
    end

    assign o_vel  = r_vel;
    assign o_done = r_done;

endmodule

`default_nettype wire

// ----- hw/rtl/euler_rotate_accel_integrate.sv -----
// strapdown zyx euler velocity integrator, top level
// depends on erai_pkg, erai_cordic, erai_rotate, erai_kmh_div
// direction and accel are registered on acceptance; speed uses the three-stage reciprocal divide by 18;
// tick runs the three parallel cordic lanes, then the shared multiplier
// throughput: one transaction at a time, next accepted as the result is taken
// reset: synchronous active low, clears attitude, accel and velocity to zero
`default_nettype none

module euler_rotate_accel_integrate (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire logic [127:0]  i_s_tdata,  // value_x, value_y, value_z, dt
    input  wire logic [1:0]    i_s_tuser,  // cmd
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    output logic [95:0]        o_m_tdata   // vel_x, vel_y, vel_z
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_ROT,
        ST_SPEED
    } t_state;

    t_state r_state;
    logic r_out_valid;
    erai_pkg::t_vec3 r_att, r_acc, r_vel;
    logic [31:0] r_dt;

    logic accept;
    erai_pkg::t_cmd cmd;
    erai_pkg::t_vec3 in_vec;
    logic lane_start, rot_start;
    logic [2:0] lane_done;
    erai_pkg::t_trig trig;
    erai_pkg::t_vec3 rot_vel;
    logic rot_done, div_done;
    erai_pkg::t_q16 div_vel;

    assign cmd = erai_pkg::t_cmd'(i_s_tuser);
    assign in_vec = i_s_tdata[95:0];
    assign o_s_tready = (r_state == ST_IDLE) && (!r_out_valid || i_m_tready);
    assign accept = i_s_tvalid && o_s_tready;
    assign lane_start = accept && (cmd == erai_pkg::CMD_TICK);
    assign rot_start = (r_state == ST_TICK) && (&lane_done);

    erai_cordic u_lane_roll (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(lane_start), .i_angle(r_att.x),
        .o_sin(trig.sr), .o_cos(trig.cr), .o_done(lane_done[0])
    );

    erai_cordic u_lane_pitch (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(lane_start), .i_angle(r_att.y),
        .o_sin(trig.sp), .o_cos(trig.cp), .o_done(lane_done[1])
    );

    erai_cordic u_lane_yaw (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(lane_start), .i_angle(r_att.z),
        .o_sin(trig.sy), .o_cos(trig.cy), .o_done(lane_done[2])
    );

    erai_rotate u_rotate (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(rot_start), .i_trig(trig),
        .i_accel(r_acc), .i_dt(r_dt), .i_vel(r_vel), .o_vel(rot_vel), .o_done(rot_done)
    );

    erai_kmh_div u_kmh_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(accept && (cmd == erai_pkg::CMD_SPEED)),
        .i_kmh(in_vec.x), .o_vel(div_vel), .o_done(div_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_att       <= '0;
            r_acc       <= '0;
            r_vel       <= '0;
        end else begin
            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        case (cmd)
                            erai_pkg::CMD_DIR: begin
                                r_att <= in_vec;
                                r_out_valid <= 1'b1;
                            end
                            erai_pkg::CMD_ACCEL: begin
                                r_acc <= in_vec;
                                r_out_valid <= 1'b1;
                            end
                            erai_pkg::CMD_SPEED: r_state <= ST_SPEED;
                            erai_pkg::CMD_TICK: begin
                                r_dt <= i_s_tdata[127:96];
                                r_state <= ST_TICK;
                            end
                            default: r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_TICK: begin
                    if (&lane_done) begin
                        r_state <= ST_ROT;
                    end
                end
                ST_ROT: begin
                    if (rot_done) begin
                        r_vel <= rot_vel;
                        r_out_valid <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                ST_SPEED: begin
                    if (div_done) begin
                        r_vel.x <= div_vel;
                        r_out_valid <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_vel;

endmodule

`default_nettype wire
